// ----- design/oqkr_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered queue package
// Shared types and codes for the ordered queue with keyed removal.
// ----------------------------------------------------------------------------
package oqkr_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_ADDED     = 2'd0;
	localparam logic [1:0] ST_REMOVED   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [15:0] handle;
		logic [15:0] player;
		logic [7:0]  color;
	} entry_t;

	typedef struct packed {
		logic in_range;
		logic load_tail;
		logic remove;
	} cell_ctrl_t;

endpackage

// ----- design/oqkr_cell.sv -----
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry, compares its key and shifts towards the head on removal.
// ----------------------------------------------------------------------------
module oqkr_cell
	import oqkr_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     cmd_entry,
	input  entry_t     next_entry,
	input  logic       hit_in,
	output logic       hit_out,
	output logic       first_hit,
	output entry_t     entry_q
);

	logic match;

	assign match     = ctrl.in_range && ctrl.remove &&
	                   (entry_q.player == cmd_entry.player) &&
	                   (entry_q.color == cmd_entry.color);
	assign hit_out   = hit_in | match;
	assign first_hit = match & ~hit_in;

	always_ff @(posedge clk) begin
		if (ctrl.load_tail) begin
			entry_q <= cmd_entry;
		end else if (ctrl.remove && ctrl.in_range && hit_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ----- design/ordered_queue_keyed_remove_unit.sv -----
// ----------------------------------------------------------------------------
// Ordered queue with keyed removal
// A bounded arrival queue kept in a row of cells, with tail append and
// removal of the oldest entry whose key matches.
// ----------------------------------------------------------------------------
// A word is issued by raising start with its fields while busy is low; it is
// taken at that clock edge. busy is then high for one cycle, in which an add
// fills the next free cell, if any, or for a removal every occupied cell
// compares its key at once and the cells behind the first match shift one
// place towards the head. The result word appears in the following cycle,
// marked by done for exactly that one cycle, and a new word may be issued in
// the cycle that done is shown, after the command and the result register.
// The receiver cannot stall: each result must be taken when done is high.
// The occupation level is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle; the block does not enforce this.
// Reset empties the queue, clears the level, busy and done; entries are kept.
// ----------------------------------------------------------------------------
module ordered_queue_keyed_remove_unit
	import oqkr_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] vehicle_handle,
	input  logic [15:0] player_number,
	input  logic [7:0]  key_colour,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] level_out,
	output logic [15:0] removed_handle,
	output logic [4:0]  entry_count
);

	localparam int CW = $clog2(DEPTH + 1);

	logic          busy_q;
	logic          op_s1;
	entry_t        cmd_s1;
	logic [15:0]   level_q;
	logic [CW-1:0] count_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [15:0]   level_out_q;
	logic [15:0]   handle_out_q;

	entry_t        entries [DEPTH];
	logic [DEPTH:0] hit;
	logic [DEPTH-1:0] first_hit;
	logic          full;
	logic          found;
	logic [15:0]   found_handle;

	assign full  = (count_q == CW'(DEPTH));
	assign found = hit[DEPTH];
	assign hit[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		entry_t     next_entry;

		assign ctrl.in_range  = (CW'(i) < count_q);
		assign ctrl.load_tail = busy_q && (op_s1 == OP_ADD) && (CW'(i) == count_q);
		assign ctrl.remove    = busy_q && (op_s1 == OP_REMOVE);

		if (i == DEPTH - 1) begin : g_last
			assign next_entry = entries[i];
		end else begin : g_mid
			assign next_entry = entries[i+1];
		end

		oqkr_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.cmd_entry  (cmd_s1),
			.next_entry (next_entry),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.first_hit  (first_hit[i]),
			.entry_q    (entries[i])
		);
	end

	always_comb begin
		found_handle = '0;
		for (int i = 0; i < DEPTH; i++) begin
			found_handle = found_handle | (entries[i].handle & {16{first_hit[i]}});
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			op_s1         <= opcode;
			cmd_s1.handle <= vehicle_handle;
			cmd_s1.player <= player_number;
			cmd_s1.color  <= key_colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
			level_q <= '0;
		end else begin
			busy_q <= start && !busy_q;
			done_q <= busy_q;
			if (cfg_wr_en) begin
				level_q <= cfg_wr_data;
			end
			if (busy_q) begin
				if (op_s1 == OP_ADD) begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
				end else if (found) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (op_s1 == OP_ADD) begin
				status_q     <= full ? ST_FULL : ST_ADDED;
				level_out_q  <= full ? 16'd0 : level_q;
				handle_out_q <= '0;
			end else begin
				status_q     <= found ? ST_REMOVED : ST_NOT_FOUND;
				level_out_q  <= '0;
				handle_out_q <= found_handle;
			end
		end
	end

	assign busy           = busy_q;
	assign done           = done_q;
	assign status         = status_q;
	assign level_out      = level_out_q;
	assign removed_handle = handle_out_q;
	assign entry_count    = 5'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");

	a_single_work_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("busy held for more than one cycle");

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> done_q)
		else $error("result strobe missing after work cycle");

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (op_s1 == OP_ADD) && !full |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("add did not grow the queue");

	a_remove_counts: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (op_s1 == OP_REMOVE) && found |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("removal did not shrink the queue");

endmodule
